// ===== hdl/frame_count_to_smpte_timecode_defines.svh =====
// Assertion macros shared by the timecode converter.
`ifndef FRAME_COUNT_TO_SMPTE_TIMECODE_DEFINES_SVH
`define FRAME_COUNT_TO_SMPTE_TIMECODE_DEFINES_SVH

`ifndef SYNTHESIS
`define FCTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("timecode converter check failed");
`define FCTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("timecode converter check failed");
`else
`define FCTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FCTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/fctc_pkg.sv =====
package fctc_pkg;

    localparam int DIV_W      = 19;
    localparam int RATE_W     = 7;
    localparam int FPH_W      = 19;
    localparam int OFFSET_W   = 32;
    localparam int HOURS_W    = 20;
    localparam int MINS_W     = 6;
    localparam int SECS_W     = 6;
    localparam int FRAME_W    = 7;
    localparam int ACC_W      = 9;
    localparam int MULT_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [HOURS_W-1:0] HOURS_MAX = 20'hFFFFF;
    localparam logic [MINS_W-1:0]  MINS_MAX  = 6'd59;
    localparam logic [FRAME_W-1:0] FRAME_MAX = 7'd119;

    localparam logic [DIV_W-1:0] C_SEC_PER_HOUR = 19'd3600;
    localparam logic [DIV_W-1:0] C_SEC_PER_MIN  = 19'd60;
    localparam logic [DIV_W-1:0] C_TEN_MIN      = 19'd17982;
    localparam logic [DIV_W-1:0] C_FIRST_MIN    = 19'd1800;
    localparam logic [DIV_W-1:0] C_LATER_MIN    = 19'd1798;
    localparam logic [DIV_W-1:0] C_DROP_SEC     = 19'd30;
    localparam logic [DIV_W-1:0] C_DROP_LABELS  = 19'd2;
    localparam logic [ACC_W-1:0] C_MIN_PER_BLK  = 9'd10;

    localparam logic [RATE_W-1:0] RATE_30  = 7'd30;
    localparam logic [RATE_W-1:0] RATE_60  = 7'd60;
    localparam logic [RATE_W-1:0] RATE_90  = 7'd90;
    localparam logic [RATE_W-1:0] RATE_120 = 7'd120;

    localparam logic [RATE_W-1:0]   RST_FRAME_RATE = 7'd24;
    localparam logic [FPH_W-1:0]    RST_DROP_FPH   = 19'd107892;
    localparam logic [OFFSET_W-1:0] RST_OFFSET     = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_RATE   = 2'd0,
        CFG_DROP_MODE    = 2'd1,
        CFG_DROP_FPH     = 2'd2,
        CFG_START_OFFSET = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [RATE_W-1:0]   frame_rate;
        logic                drop_mode;
        logic [FPH_W-1:0]    drop_fph;
        logic [OFFSET_W-1:0] start_offset;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic full;
    } t_div_cmd;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_HOUR  = 8'b0000_0100,
        S_MIN   = 8'b0000_1000,
        S_SEC   = 8'b0001_0000,
        S_DMIN  = 8'b0010_0000,
        S_DWALK = 8'b0100_0000,
        S_DSEC  = 8'b1000_0000
    } t_state;

    function automatic logic [MULT_W-1:0] f_drop_mult(input logic [RATE_W-1:0] rate);
        logic [MULT_W-1:0] m;
        unique case (rate)
            RATE_30:  m = 3'd1;
            RATE_60:  m = 3'd2;
            RATE_90:  m = 3'd3;
            RATE_120: m = 3'd4;
            default:  m = 3'd0;
        endcase
        return m;
    endfunction

    function automatic logic [MINS_W-1:0] f_sat_min(input logic [ACC_W-1:0] v);
        return (v > ACC_W'(MINS_MAX)) ? MINS_MAX : v[MINS_W-1:0];
    endfunction

    function automatic logic [FRAME_W-1:0] f_sat_frame(input logic [DIV_W-1:0] v);
        return (v > DIV_W'(FRAME_MAX)) ? FRAME_MAX : v[FRAME_W-1:0];
    endfunction

endpackage

// ===== hdl/fctc_div.sv =====
module fctc_div #(
    parameter int DW = 34
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fctc_pkg::t_div_cmd        i_cmd,
    input  logic [DW-1:0]             i_dividend,
    input  logic [fctc_pkg::DIV_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [DW-1:0]             o_quot,
    output logic [fctc_pkg::DIV_W-1:0] o_rem
);
    import fctc_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DW-1:0]    r_q;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;

    logic [DIV_W:0]   trial;
    logic             ge;
    logic [DIV_W:0]   diff;

    assign trial = {r_rem, r_q[DW-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            if (i_cmd.full) begin
                r_q   <= i_dividend;
                r_cnt <= CW'(DW);
            end else begin
                r_q   <= DW'(i_dividend[DIV_W-1:0]) << (DW - DIV_W);
                r_cnt <= CW'(DIV_W);
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            r_q   <= {r_q[DW-2:0], ge};
            r_rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/fctc_ctrl.sv =====
module fctc_ctrl #(
    parameter int FRAME_BITS = 32,
    parameter int XW         = 34
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fctc_pkg::t_cfg               i_cfg,
    input  logic                         i_start,
    input  logic signed [FRAME_BITS-1:0] i_frame_number,
    output logic                         o_busy,
    output fctc_pkg::t_div_cmd           o_div_cmd,
    output logic [XW-1:0]                o_div_dividend,
    output logic [fctc_pkg::DIV_W-1:0]   o_div_divisor,
    input  logic                         i_div_done,
    input  logic [XW-1:0]                i_div_quot,
    input  logic [fctc_pkg::DIV_W-1:0]   i_div_rem,
    output logic                         o_valid,
    output logic                         o_is_negative,
    output logic [fctc_pkg::HOURS_W-1:0] o_hours,
    output logic [fctc_pkg::MINS_W-1:0]  o_minutes,
    output logic [fctc_pkg::SECS_W-1:0]  o_seconds,
    output logic [fctc_pkg::FRAME_W-1:0] o_frame_label,
    output logic                         o_drop_applied
);
    import fctc_pkg::*;

    t_state               r_state, n_state;
    logic                 r_valid, n_valid;
    logic signed [XW-1:0] r_x, n_x;
    logic                 r_neg, n_neg;
    logic                 r_drop, n_drop;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [HOURS_W-1:0]   r_hours, n_hours;
    logic [MINS_W-1:0]    r_mins, n_mins;
    logic [SECS_W-1:0]    r_secs, n_secs;
    logic [FRAME_W-1:0]   r_frames, n_frames;

    logic [RATE_W-1:0]    rate_eff;
    logic [DIV_W-1:0]     fph_eff;
    logic [MULT_W-1:0]    mult;
    logic                 drop_ok;
    logic [DIV_W-1:0]     nd_hour, nd_min, nd_sec;
    logic [DIV_W-1:0]     d_ten, d_first, d_later, d_sec, d_two;
    logic signed [XW-1:0] f_ext, off_ext;
    logic [XW-1:0]        x_abs;
    logic [ACC_W-1:0]     mins10, walk_mins;
    logic [HOURS_W-1:0]   hours_sat;

    assign rate_eff = (i_cfg.frame_rate == '0) ? RATE_W'(1) : i_cfg.frame_rate;
    assign fph_eff  = (i_cfg.drop_fph == '0) ? DIV_W'(1) : i_cfg.drop_fph;
    assign mult     = f_drop_mult(rate_eff);
    assign drop_ok  = mult != '0;

    assign nd_hour = DIV_W'(rate_eff) * C_SEC_PER_HOUR;
    assign nd_min  = DIV_W'(rate_eff) * C_SEC_PER_MIN;
    assign nd_sec  = DIV_W'(rate_eff);
    assign d_ten   = DIV_W'(mult) * C_TEN_MIN;
    assign d_first = DIV_W'(mult) * C_FIRST_MIN;
    assign d_later = DIV_W'(mult) * C_LATER_MIN;
    assign d_sec   = DIV_W'(mult) * C_DROP_SEC;
    assign d_two   = DIV_W'(mult) * C_DROP_LABELS;

    assign f_ext   = XW'(i_frame_number);
    assign off_ext = XW'(signed'(i_cfg.start_offset));
    assign x_abs   = r_x[XW-1] ? (XW'(0) - r_x) : r_x;

    assign mins10    = ACC_W'(i_div_quot[4:0]) * C_MIN_PER_BLK;
    assign walk_mins = r_acc + ACC_W'(1) + ACC_W'(i_div_quot[3:0]);
    assign hours_sat = (i_div_quot > XW'(HOURS_MAX)) ? HOURS_MAX
                                                     : i_div_quot[HOURS_W-1:0];

    always_comb begin
        n_state        = r_state;
        n_valid        = 1'b0;
        n_x            = r_x;
        n_neg          = r_neg;
        n_drop         = r_drop;
        n_acc          = r_acc;
        n_hours        = r_hours;
        n_mins         = r_mins;
        n_secs         = r_secs;
        n_frames       = r_frames;
        o_div_cmd      = '0;
        o_div_dividend = XW'(i_div_rem);
        o_div_divisor  = nd_sec;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_x     = f_ext + off_ext - XW'(1);
                    n_drop  = i_cfg.drop_mode & drop_ok;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_neg          = r_x[XW-1];
                o_div_cmd      = '{start: 1'b1, full: 1'b1};
                o_div_dividend = x_abs;
                o_div_divisor  = r_drop ? fph_eff : nd_hour;
                n_state        = S_HOUR;
            end
            S_HOUR: begin
                if (i_div_done) begin
                    n_hours         = hours_sat;
                    o_div_cmd.start = 1'b1;
                    if (r_drop) begin
                        o_div_divisor = d_ten;
                        n_state       = S_DMIN;
                    end else begin
                        o_div_divisor = nd_min;
                        n_state       = S_MIN;
                    end
                end
            end
            S_MIN: begin
                if (i_div_done) begin
                    n_mins          = i_div_quot[MINS_W-1:0];
                    o_div_cmd.start = 1'b1;
                    o_div_divisor   = nd_sec;
                    n_state         = S_SEC;
                end
            end
            S_SEC: begin
                if (i_div_done) begin
                    n_secs   = i_div_quot[SECS_W-1:0];
                    n_frames = f_sat_frame(i_div_rem);
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DMIN: begin
                if (i_div_done) begin
                    if (r_neg) begin
                        // Negative positions skip both walks.
                        n_mins   = f_sat_min(mins10);
                        n_secs   = '0;
                        n_frames = f_sat_frame(i_div_rem);
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end else if (i_div_rem >= d_first) begin
                        n_acc           = mins10;
                        o_div_cmd.start = 1'b1;
                        o_div_dividend  = XW'(i_div_rem - d_first);
                        o_div_divisor   = d_later;
                        n_state         = S_DWALK;
                    end else begin
                        n_mins          = f_sat_min(mins10);
                        o_div_cmd.start = 1'b1;
                        o_div_divisor   = d_sec;
                        n_state         = S_DSEC;
                    end
                end
            end
            S_DWALK: begin
                if (i_div_done) begin
                    // Dropped labels are folded in before the seconds split.
                    n_mins          = f_sat_min(walk_mins);
                    o_div_cmd.start = 1'b1;
                    o_div_dividend  = XW'(i_div_rem + d_two);
                    o_div_divisor   = d_sec;
                    n_state         = S_DSEC;
                end
            end
            S_DSEC: begin
                if (i_div_done) begin
                    n_secs   = i_div_quot[SECS_W-1:0];
                    n_frames = f_sat_frame(i_div_rem);
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_neg    <= n_neg;
        r_drop   <= n_drop;
        r_acc    <= n_acc;
        r_hours  <= n_hours;
        r_mins   <= n_mins;
        r_secs   <= n_secs;
        r_frames <= n_frames;
    end

    assign o_busy         = r_state != S_IDLE;
    assign o_valid        = r_valid;
    assign o_is_negative  = r_neg;
    assign o_hours        = r_hours;
    assign o_minutes      = r_mins;
    assign o_seconds      = r_secs;
    assign o_frame_label  = r_frames;
    assign o_drop_applied = r_drop;

endmodule

// ===== hdl/frame_count_to_smpte_timecode.sv =====
// XW is the wider of FRAME_BITS and 32 plus 2, capped at 64 (34). One item is in flight at a
// time; the shared restoring divider produces one quotient bit per cycle, XW steps for the
// hour split and 19 steps for each later split.
// A new start is taken in the cycle the result strobe is shown; results are never stalled.
// Synchronous active-low reset idles the sequencer and loads the register defaults.
`include "frame_count_to_smpte_timecode_defines.svh"

module frame_count_to_smpte_timecode #(
    parameter int FRAME_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [FRAME_BITS-1:0]      i_frame_number,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fctc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fctc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_result_valid,
    output logic                              o_is_negative,
    output logic [fctc_pkg::HOURS_W-1:0]      o_hours,
    output logic [fctc_pkg::MINS_W-1:0]       o_minutes,
    output logic [fctc_pkg::SECS_W-1:0]       o_seconds,
    output logic [fctc_pkg::FRAME_W-1:0]      o_frame_label,
    output logic                              o_drop_applied
);
    import fctc_pkg::*;

    localparam int WIDE = (FRAME_BITS > OFFSET_W) ? FRAME_BITS : OFFSET_W;
    localparam int XW   = (WIDE + 2 > 64) ? 64 : WIDE + 2;

    t_cfg             r_cfg;
    t_div_cmd         div_cmd;
    logic [XW-1:0]    div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic             div_done;
    logic [XW-1:0]    div_quot;
    logic [DIV_W-1:0] div_rem;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_rate   <= RST_FRAME_RATE;
            r_cfg.drop_mode    <= 1'b0;
            r_cfg.drop_fph     <= RST_DROP_FPH;
            r_cfg.start_offset <= RST_OFFSET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_RATE:   r_cfg.frame_rate   <= i_cfg_data[RATE_W-1:0];
                CFG_DROP_MODE:    r_cfg.drop_mode    <= i_cfg_data[0];
                CFG_DROP_FPH:     r_cfg.drop_fph     <= i_cfg_data[FPH_W-1:0];
                CFG_START_OFFSET: r_cfg.start_offset <= i_cfg_data[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fctc_ctrl #(
        .FRAME_BITS (FRAME_BITS),
        .XW         (XW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_start        (start),
        .i_frame_number (i_frame_number),
        .o_busy         (busy),
        .o_div_cmd      (div_cmd),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .i_div_done     (div_done),
        .i_div_quot     (div_quot),
        .i_div_rem      (div_rem),
        .o_valid        (o_result_valid),
        .o_is_negative  (o_is_negative),
        .o_hours        (o_hours),
        .o_minutes      (o_minutes),
        .o_seconds      (o_seconds),
        .o_frame_label  (o_frame_label),
        .o_drop_applied (o_drop_applied)
    );

    fctc_div #(
        .DW (XW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (div_cmd),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    `FCTC_ASSERT_IMPLY(a_result_when_idle, i_clk, i_rst_n, o_result_valid, !busy)
    `FCTC_ASSERT_NEXT(a_start_goes_busy, i_clk, i_rst_n, start && !busy, busy)
    `FCTC_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_result_valid, !o_result_valid)
    `FCTC_ASSERT_IMPLY(a_drop_requested, i_clk, i_rst_n, o_result_valid && o_drop_applied, r_cfg.drop_mode)

endmodule

// ===== test/frame_count_to_smpte_timecode_tb.sv =====
`timescale 1ns / 1ps

module frame_count_to_smpte_timecode_tb;
    import fctc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_COUNT = 12;
    localparam int PHASE_ITEMS = 158;

    typedef struct packed {
        bit               neg;
        bit [HOURS_W-1:0] hours;
        bit [MINS_W-1:0]  minutes;
        bit [SECS_W-1:0]  seconds;
        bit [FRAME_W-1:0] frame_label;
        bit               drop;
    } timecode_t;

    class timecode_scoreboard;
        bit [RATE_W-1:0]   rate_reg;
        bit                drop_reg;
        bit [FPH_W-1:0]    fph_reg;
        bit [OFFSET_W-1:0] offset_reg;
        timecode_t         expected_codes[$];
        int unsigned       fail_count;

        function new();
            rate_reg   = RST_FRAME_RATE;
            drop_reg   = 1'b0;
            fph_reg    = RST_DROP_FPH;
            offset_reg = RST_OFFSET;
            fail_count = 0;
        endfunction

        function void set_register(t_cfg_idx idx, bit [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FRAME_RATE:   rate_reg = data[RATE_W-1:0];
                CFG_DROP_MODE:    drop_reg = data[0];
                CFG_DROP_FPH:     fph_reg = data[FPH_W-1:0];
                CFG_START_OFFSET: offset_reg = data[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        function longint magnitude(longint v, longint lim);
            longint m;
            m = (v < 0) ? -v : v;
            return (m > lim) ? lim : m;
        endfunction

        function timecode_t to_timecode(bit [31:0] frame);
            timecode_t tc;
            longint rate, x, hrs, mins, secs, lbl, mult, hour_len, step;
            bit use_drop;
            mins = 0;
            secs = 0;
            rate = (rate_reg == 0) ? 1 : longint'(rate_reg);
            x = longint'($signed(frame)) - 1 + longint'($signed(offset_reg));
            use_drop = drop_reg && (rate % 30 == 0);
            if (!use_drop) begin
                hrs = x / (3600 * rate);
                x -= hrs * 3600 * rate;
                mins = x / (60 * rate);
                x -= mins * 60 * rate;
                secs = x / rate;
                x -= secs * rate;
                lbl = x;
            end else begin
                mult = rate / 30;
                hour_len = (fph_reg == 0) ? 1 : longint'(fph_reg);
                hrs = x / hour_len;
                x -= hrs * hour_len;
                mins = x / (17982 * mult);
                x -= mins * 17982 * mult;
                mins *= 10;
                if (x >= 1800 * mult) begin
                    mins++;
                    x -= 1800 * mult;
                    while (x >= 1798 * mult) begin
                        mins++;
                        x -= 1798 * mult;
                    end
                end
                step = (mins % 10 == 0) ? 30 * mult : 28 * mult;
                if (x >= step) begin
                    secs++;
                    x -= step;
                    while (x >= 30 * mult) begin
                        secs++;
                        x -= 30 * mult;
                    end
                end
                lbl = x;
                if (mins % 10 != 0 && secs == 0) begin
                    lbl += 2 * mult;
                end
            end
            tc.neg         = (hrs < 0) || (mins < 0) || (secs < 0) || (lbl < 0);
            tc.hours       = HOURS_W'(magnitude(hrs, 1048575));
            tc.minutes     = MINS_W'(magnitude(mins, 59));
            tc.seconds     = SECS_W'(magnitude(secs, 59));
            tc.frame_label = FRAME_W'(magnitude(lbl, 119));
            tc.drop        = use_drop;
            return tc;
        endfunction

        function void note_frame(bit [31:0] frame);
            expected_codes.push_back(to_timecode(frame));
        endfunction

        task report_mismatch(string what);
            $display("%0t: %s", $time, what);
            fail_count++;
        endtask

        task compare_field(string name, longint got, longint want);
            if (got != want) begin
                report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
            end
        endtask

        task check_result(timecode_t got);
            timecode_t want;
            if (expected_codes.size() == 0) begin
                report_mismatch("result beat with no conversion pending");
                return;
            end
            want = expected_codes.pop_front();
            compare_field("is_negative", got.neg, want.neg);
            compare_field("hours", got.hours, want.hours);
            compare_field("minutes", got.minutes, want.minutes);
            compare_field("seconds", got.seconds, want.seconds);
            compare_field("frame_label", got.frame_label, want.frame_label);
            compare_field("drop_applied", got.drop, want.drop);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic signed [31:0]    i_frame_number;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_result_valid;
    logic                  o_is_negative;
    logic [HOURS_W-1:0]    o_hours;
    logic [MINS_W-1:0]     o_minutes;
    logic [SECS_W-1:0]     o_seconds;
    logic [FRAME_W-1:0]    o_frame_label;
    logic                  o_drop_applied;

    timecode_scoreboard tc_sb = new();
    int unsigned        cycle_count = 0;
    int unsigned        max_gap = 8;

    frame_count_to_smpte_timecode i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_frame_number (i_frame_number),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_is_negative  (o_is_negative),
        .o_hours        (o_hours),
        .o_minutes      (o_minutes),
        .o_seconds      (o_seconds),
        .o_frame_label  (o_frame_label),
        .o_drop_applied (o_drop_applied)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("frame_count_to_smpte_timecode: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            tc_sb.check_result({o_is_negative, o_hours, o_minutes, o_seconds,
                                o_frame_label, o_drop_applied});
        end
    end

    task send_frame(logic [31:0] frame);
        int unsigned gap;
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_frame_number = frame;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tc_sb.note_frame(frame);
        @(negedge i_clk);
    endtask

    task drain_results();
        start = 1'b0;
        while (tc_sb.expected_codes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tc_sb.set_register(idx, data);
        @(negedge i_clk);
    endtask

    // Unused upper data bits carry noise; the block must ignore them.
    task configure(int unsigned rate, bit drop, int unsigned fph, logic [31:0] offset);
        write_register(CFG_FRAME_RATE, ($urandom() << RATE_W) | rate);
        write_register(CFG_DROP_MODE, ($urandom() << 1) | drop);
        write_register(CFG_DROP_FPH, ($urandom() << FPH_W) | fph);
        write_register(CFG_START_OFFSET, offset);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] small_offset();
        return 32'(int'($urandom_range(0, 200000)) - 100000);
    endfunction

    task apply_phase(int p);
        case (p)
            0:  configure(24, 1'b0, 107892, 32'd0);
            1:  configure(30, 1'b1, 107892, small_offset());
            2:  configure(60, 1'b1, 215784, small_offset());
            3:  configure(90, 1'b1, 323676, 32'd0);
            4:  configure(120, 1'b1, 431568, small_offset());
            5:  configure(0, 1'b1, 107892, small_offset());
            6:  configure(127, 1'b1, 0, small_offset());
            7:  configure(30, 1'b1, 0, 32'd0);
            8:  configure(60, 1'b1, 524287, small_offset());
            9:  configure($urandom_range(0, 127), 1'($urandom()), $urandom_range(0, 524287),
                          $urandom());
            10: configure(30, 1'b1, $urandom_range(1, 524287), 32'h8000_0000);
            default: configure(25, 1'b0, 1, 32'h7FFF_FFFF);
        endcase
    endtask

    // Mostly positions within a few hours of zero, and near minute starts, where in
    // drop mode the label skipping lives.
    function automatic logic [31:0] pick_frame();
        int unsigned kind, blk;
        longint rate, mult, hour_len, x;
        bit dmode;
        rate = (tc_sb.rate_reg == 0) ? 1 : longint'(tc_sb.rate_reg);
        dmode = tc_sb.drop_reg && (rate % 30 == 0);
        mult = rate / 30;
        if (dmode) begin
            hour_len = (tc_sb.fph_reg == 0) ? 1 : longint'(tc_sb.fph_reg);
        end else begin
            hour_len = 3600 * rate;
        end
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            return $urandom();
        end
        if (kind < 7) begin
            x = longint'($urandom_range(0, 32'(3 * hour_len))) - hour_len;
        end else begin
            if (dmode) begin
                blk = $urandom_range(0, 9);
                x = longint'($urandom_range(0, 5)) * 17982 * mult;
                if (blk != 0) begin
                    x += 1800 * mult + longint'(blk - 1) * 1798 * mult;
                end
            end else begin
                x = longint'($urandom_range(0, 59)) * 60 * rate;
            end
            x += longint'($urandom_range(0, 32'(6 * mult + 6))) - (3 * mult + 3);
            if ($urandom_range(0, 3) == 0) begin
                x = -x;
            end
        end
        return 32'(x + 1 - longint'($signed(tc_sb.offset_reg)));
    endfunction

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_frame_number = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FRAME_RATE;
        i_cfg_data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_frame(32'd1);
        send_frame(32'd0);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'h7FFF_FFFF);
        send_frame(32'h8000_0000);
        send_frame(32'd25);
        send_frame(32'd86401);
        send_frame(32'd86400 * 24 + 1);
        drain_results();

        configure(30, 1'b1, 107892, 32'd0);
        send_frame(32'd1800);
        send_frame(32'd1801);
        send_frame(32'd1802);
        send_frame(32'd17982);
        send_frame(32'd17983);
        send_frame(32'd107892);
        send_frame(32'd107893);
        send_frame(32'd0);
        send_frame(32'hFFFF_F8F9);
        send_frame(32'hFFFF_B9C2);
        send_frame(32'h7FFF_FFFF);
        send_frame(32'h8000_0000);
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            apply_phase(p);
            max_gap = (p % 4 == 3) ? 0 : 8;
            repeat (PHASE_ITEMS) send_frame(pick_frame());
            drain_results();
        end

        repeat (120) @(posedge i_clk);
        if (tc_sb.fail_count == 0) begin
            $display("frame_count_to_smpte_timecode: match");
        end else begin
            $display("frame_count_to_smpte_timecode: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fctc_pkg.sv
hdl/fctc_div.sv
hdl/fctc_ctrl.sv
hdl/frame_count_to_smpte_timecode.sv
test/frame_count_to_smpte_timecode_tb.sv
